// ----- hw/rtl/chm_pkg.sv -----
`default_nettype none
package chm_pkg;

  localparam int unsigned BucketsDef  = 31;
  localparam int unsigned CapacityDef = 64;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned FuncW = 3;
  localparam int unsigned StatW = 3;

  // request codes
  localparam logic [FuncW-1:0] FUNC_INSERT = 3'd0;
  localparam logic [FuncW-1:0] FUNC_UPDATE = 3'd1;
  localparam logic [FuncW-1:0] FUNC_UPSERT = 3'd2;
  localparam logic [FuncW-1:0] FUNC_GET    = 3'd3;
  localparam logic [FuncW-1:0] FUNC_REMOVE = 3'd4;

  // result codes
  localparam logic [StatW-1:0] STAT_DONE    = 3'd0;
  localparam logic [StatW-1:0] STAT_NEW     = 3'd1;
  localparam logic [StatW-1:0] STAT_ABSENT  = 3'd2;
  localparam logic [StatW-1:0] STAT_PRESENT = 3'd3;
  localparam logic [StatW-1:0] STAT_NOROOM  = 3'd4;

endpackage
`default_nettype wire

// ----- hw/rtl/chm_ram.sv -----
`default_nettype none
module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port: a write cycle does not read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/chm_mod.sv -----
`default_nettype none
module chm_mod #(
  parameter int unsigned BUCKETS = chm_pkg::BucketsDef,
  parameter int unsigned BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [chm_pkg::KeyW-1:0]  key_i,
  output logic                           done_o,
  output logic      [BW-1:0]             rem_o
);
  import chm_pkg::*;

  // one byte per cycle, MSB first; 8 restoring steps reduce r*256+byte
  localparam int unsigned TW    = BW + 9;
  localparam int unsigned Steps = KeyW / 8;

  logic [KeyW-1:0] key_q;
  logic [1:0]      cnt_q;
  logic            busy_q;
  logic [BW-1:0]   rem_q;
  logic            done_q;
  logic [TW-1:0]   t;
  logic [BW-1:0]   rem_d;

  always_comb begin
    t = {1'b0, rem_q, key_q[KeyW-1 -: 8]};
    for (int i = 7; i >= 0; i--) begin
      if (t >= (TW'(BUCKETS) << i)) begin
        t = t - (TW'(BUCKETS) << i);
      end
    end
    rem_d = t[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      rem_q <= '0;
    end else if (busy_q) begin
      key_q <= key_q << 8;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- hw/rtl/chained_hash_map_engine.sv -----
`default_nettype none
// Chained hash map: key/value store over a pool of CAPACITY nodes linked into
// BUCKETS chains (bucket = key mod BUCKETS). Bucket heads and nodes each live
// in a single-port RAM with a registered read. After reset the block sweeps the
// bucket RAM to null before it takes the first request.
// One request is in flight at a time. The idle state takes the transfer, the
// hash state runs the 4 byte steps of the modulo and waits for its done flag,
// the last hash cycle issuing the bucket head read, the head state receives
// the bucket head, the walk state visits each chain node, the act state acts on
// the node and bucket RAMs (with a take or unlink state when a free-list take
// or a remove needs a second RAM access), and the fin state posts the result.
// Unused function codes skip the walk and go straight to posting the result.
// The result sits in an output register, so a finished result waiting on the
// master side does not stall the walk of the next request until it completes.
module chained_hash_map_engine #(
  parameter int unsigned BUCKETS  = chm_pkg::BucketsDef,
  parameter int unsigned CAPACITY = chm_pkg::CapacityDef,
  parameter int unsigned CW       = $clog2(CAPACITY + 1),
  parameter int unsigned IDW      = ((chm_pkg::FuncW + 2*chm_pkg::KeyW + 7) / 8) * 8,
  parameter int unsigned ODW      = ((chm_pkg::StatW + chm_pkg::DataW + CW + 7) / 8) * 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [IDW-1:0] s_axis_tdata,  // func[2:0], key[34:3], data_word[66:35]
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic      [ODW-1:0] m_axis_tdata   // status[2:0], prior_value[34:3],
                                             // entry_count[41:35]
);
  import chm_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = CW;                 // link: node index or null
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = KeyW + DataW + LW;  // node word {key, value, link}
  localparam logic [LW-1:0] Nil = LW'(CAPACITY);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_HEAD, S_WALK, S_ACT, S_TAKE, S_UNLINK, S_FIN
  } state_e;

  state_e state_q;

  logic [FuncW-1:0] func_q;
  logic [KeyW-1:0]  key_q;
  logic [DataW-1:0] data_q;
  logic [BW-1:0]    bkt_q, clr_q;
  logic [LW-1:0]    head_q, cur_q, prev_q, hit_q, hit_link_q, free_q;
  logic [LW-1:0]    unused_q, count_q, steps_q;
  logic [KeyW-1:0]  prev_key_q;
  logic [DataW-1:0] prev_val_q, hit_val_q;
  logic             found_q;
  logic [StatW-1:0] res_stat_q, out_stat_q;
  logic [DataW-1:0] res_prior_q, out_prior_q;
  logic [LW-1:0]    out_count_q;
  logic             out_valid_q;
  logic             out_load;

  // modulo unit
  logic          mod_done;
  logic [BW-1:0] mod_rem;
  logic          in_xfer;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  // result register takes a new transfer when empty or being drained
  assign out_load      = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  chm_mod #(.BUCKETS(BUCKETS), .BW(BW)) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_xfer),
    .key_i  (s_axis_tdata[FuncW +: KeyW]),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // RAMs
  logic          bk_we;
  logic [BW-1:0] bk_addr;
  logic [LW-1:0] bk_wdata, bk_rdata;
  logic          nd_we;
  logic [AW-1:0] nd_addr;
  logic [NW-1:0] nd_wdata, nd_rdata;

  chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS), .AW(BW)) u_bkt_ram (
    .clk_i(clk_i), .we_i(bk_we), .addr_i(bk_addr), .wdata_i(bk_wdata), .rdata_o(bk_rdata)
  );

  chm_ram #(.WIDTH(NW), .DEPTH(CAPACITY), .AW(AW)) u_node_ram (
    .clk_i(clk_i), .we_i(nd_we), .addr_i(nd_addr), .wdata_i(nd_wdata), .rdata_o(nd_rdata)
  );

  logic [KeyW-1:0]  rd_key;
  logic [DataW-1:0] rd_val;
  logic [LW-1:0]    rd_link;
  logic             key_hit, walk_end, is_ins;

  assign rd_key   = nd_rdata[NW-1 -: KeyW];
  assign rd_val   = nd_rdata[LW +: DataW];
  assign rd_link  = nd_rdata[LW-1:0];
  assign key_hit  = (rd_key == key_q);
  // chain ends on a null/out-of-range link or after CAPACITY nodes
  assign walk_end = (rd_link >= Nil) || ({1'b0, steps_q} + 1'b1 >= {1'b0, Nil});
  assign is_ins   = (func_q == FUNC_INSERT) || (func_q == FUNC_UPSERT);

  // RAM port control
  always_comb begin
    bk_we    = 1'b0;
    bk_addr  = bkt_q;
    bk_wdata = Nil;
    nd_we    = 1'b0;
    nd_addr  = cur_q[AW-1:0];
    nd_wdata = {key_q, data_q, head_q};
    case (state_q)
      S_CLR: begin
        bk_we   = 1'b1;
        bk_addr = clr_q;
      end
      S_HASH: bk_addr = mod_rem;
      S_HEAD: nd_addr = bk_rdata[AW-1:0];
      S_WALK: nd_addr = rd_link[AW-1:0];
      S_ACT: begin
        if (found_q) begin
          if (func_q == FUNC_UPDATE || func_q == FUNC_UPSERT) begin
            nd_we    = 1'b1;
            nd_addr  = hit_q[AW-1:0];
            nd_wdata = {key_q, data_q, hit_link_q};
          end else if (func_q == FUNC_REMOVE) begin
            if (prev_q < Nil) begin
              nd_we    = 1'b1;
              nd_addr  = prev_q[AW-1:0];
              nd_wdata = {prev_key_q, prev_val_q, hit_link_q};
            end else begin
              bk_we    = 1'b1;
              bk_wdata = hit_link_q;
            end
          end
        end else if (is_ins) begin
          if (free_q < Nil) begin
            nd_addr = free_q[AW-1:0];
          end else if (unused_q < Nil) begin
            nd_we    = 1'b1;
            nd_addr  = unused_q[AW-1:0];
            bk_we    = 1'b1;
            bk_wdata = unused_q;
          end
        end
      end
      S_TAKE: begin
        nd_we    = 1'b1;
        nd_addr  = free_q[AW-1:0];
        bk_we    = 1'b1;
        bk_wdata = free_q;
      end
      S_UNLINK: begin
        nd_we    = 1'b1;
        nd_addr  = hit_q[AW-1:0];
        nd_wdata = {key_q, hit_val_q, free_q};
      end
      default: ;
    endcase
  end

  // sequencer, free list and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      free_q      <= Nil;
      unused_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BW'(BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            func_q      <= s_axis_tdata[FuncW-1:0];
            key_q       <= s_axis_tdata[FuncW +: KeyW];
            data_q      <= s_axis_tdata[FuncW+KeyW +: DataW];
            res_stat_q  <= STAT_DONE;
            res_prior_q <= '0;
            state_q     <= (s_axis_tdata[FuncW-1:0] > FUNC_REMOVE) ? S_FIN : S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            bkt_q   <= mod_rem;
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          head_q  <= bk_rdata;
          cur_q   <= bk_rdata;
          prev_q  <= Nil;
          steps_q <= '0;
          found_q <= 1'b0;
          state_q <= (bk_rdata >= Nil) ? S_ACT : S_WALK;
        end
        S_WALK: begin
          if (key_hit) begin
            found_q    <= 1'b1;
            hit_q      <= cur_q;
            hit_val_q  <= rd_val;
            hit_link_q <= rd_link;
            state_q    <= S_ACT;
          end else begin
            prev_q     <= cur_q;
            prev_key_q <= rd_key;
            prev_val_q <= rd_val;
            cur_q      <= rd_link;
            steps_q    <= steps_q + 1'b1;
            if (walk_end) begin
              state_q <= S_ACT;
            end
          end
        end
        S_ACT: begin
          state_q <= S_FIN;
          if (found_q) begin
            case (func_q)
              FUNC_INSERT: res_stat_q <= STAT_PRESENT;
              FUNC_UPDATE, FUNC_UPSERT, FUNC_GET: res_prior_q <= hit_val_q;
              FUNC_REMOVE: state_q <= S_UNLINK;
              default: ;
            endcase
          end else if (is_ins) begin
            if (free_q < Nil) begin
              state_q <= S_TAKE;
            end else if (unused_q < Nil) begin
              unused_q   <= unused_q + 1'b1;
              count_q    <= count_q + 1'b1;
              res_stat_q <= (func_q == FUNC_UPSERT) ? STAT_NEW : STAT_DONE;
            end else begin
              res_stat_q <= STAT_NOROOM;
            end
          end else begin
            res_stat_q <= STAT_ABSENT;
          end
        end
        S_TAKE: begin
          free_q     <= rd_link;
          count_q    <= count_q + 1'b1;
          res_stat_q <= (func_q == FUNC_UPSERT) ? STAT_NEW : STAT_DONE;
          state_q    <= S_FIN;
        end
        S_UNLINK: begin
          free_q <= hit_q;
          if (count_q != '0) begin
            count_q <= count_q - 1'b1;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stat_q  <= res_stat_q;
      out_prior_q <= res_prior_q;
      out_count_q <= count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'({out_count_q, out_prior_q, out_stat_q});

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Nil) else $error("entry count above capacity");

  a_unused_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unused_q <= Nil) else $error("pool mark above capacity");

  a_count_vs_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= unused_q) else $error("more entries than nodes handed out");

  a_walk_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> cur_q < Nil) else $error("chain walk on null node");

endmodule
`default_nettype wire
